// ----- src/sxxh_pkg.sv -----
// Shared types, constants and helpers for the streaming 64-bit hash core.
package sxxh_pkg;

  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int CNT_W    = 4;
  localparam int LEN_W    = 32;
  localparam int IN_TDATA_W = 104;  // 64 + 4 + 32 bits, padded to whole bytes

  localparam logic [WORD_W-1:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [WORD_W-1:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [WORD_W-1:0] P3 = 64'h165667B19E3779F9;
  localparam logic [WORD_W-1:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [WORD_W-1:0] P5 = 64'h27D4EB2F165667C5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT_LOAD,
    ST_INIT_MUL,
    ST_WORD_LOAD,
    ST_FULL_MUL1,
    ST_FULL_MUL2,
    ST_FULL_MUL3,
    ST_TAIL_MUL1,
    ST_TAIL_MUL2,
    ST_FIN_LOAD,
    ST_FIN_MUL1,
    ST_FIN_MUL2
  } state_t;

  // Partial product pass of the 64x64 low-half multiply.
  typedef enum logic [1:0] {
    PH_LL,
    PH_LH,
    PH_HL
  } phase_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_INIT,
    LD_WORD,
    LD_FIN
  } load_t;

  typedef enum logic [1:0] {
    K_P1,
    K_P2,
    K_P3
  } ksel_t;

  typedef enum logic [2:0] {
    POST_NONE,
    POST_ACC,
    POST_T_ROT31,
    POST_XOR_ROT27,
    POST_ACC_P4,
    POST_ACC_XOR,
    POST_T_XS29,
    POST_OUT
  } post_t;

  typedef struct packed {
    logic   capture;
    load_t  load;
    logic   mul_en;
    phase_t phase;
    ksel_t  ksel;
    post_t  post;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic zero;
    logic in_msg;
    logic out_free;
  } stat_t;

  function automatic logic [WORD_W-1:0] rotl31(input logic [WORD_W-1:0] x);
    return {x[WORD_W-32:0], x[WORD_W-1:WORD_W-31]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl27(input logic [WORD_W-1:0] x);
    return {x[WORD_W-28:0], x[WORD_W-1:WORD_W-27]};
  endfunction

endpackage

// ----- src/sxxh_mul.sv -----
// Shared multiplier: 64x64 low-half product in three 32x32 passes.
module sxxh_mul
  import sxxh_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  phase_t            phase,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] sum
);

  logic [HALF_W-1:0] x;
  logic [HALF_W-1:0] y;
  logic [WORD_W-1:0] pp;
  logic [WORD_W-1:0] prod;

  always_comb begin
    case (phase)
      PH_LL: begin
        x = a[HALF_W-1:0];
        y = b[HALF_W-1:0];
      end
      PH_LH: begin
        x = a[HALF_W-1:0];
        y = b[WORD_W-1:HALF_W];
      end
      PH_HL: begin
        x = a[WORD_W-1:HALF_W];
        y = b[HALF_W-1:0];
      end
      default: begin
        x = a[HALF_W-1:0];
        y = b[HALF_W-1:0];
      end
    endcase
  end

  assign pp = x * y;

  // Cross terms only reach the upper half of the result.
  always_comb begin
    case (phase)
      PH_LL:   sum = pp;
      default: sum = prod + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= sum;
    end
  end

endmodule

// ----- src/sxxh_dp.sv -----
// Datapath: input capture, seed, accumulator, operand register and output slot.
module sxxh_dp
  import sxxh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [WORD_W-1:0]     cfg_data,
  input  logic [IN_TDATA_W-1:0] in_data,
  input  logic                  in_user,
  input  logic                  in_last,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_W-1:0]     out_data
);

  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              first_r;
  logic              last_r;
  logic [LEN_W-1:0]  len_in;
  logic [LEN_W-1:0]  saved_len;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] acc;
  logic              in_msg;
  logic [WORD_W-1:0] kval;
  logic [WORD_W-1:0] p;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] fin_h;
  logic [WORD_W-1:0] acc_x;
  logic              full;

  assign full = cnt_r[CNT_W-1];  // counts of eight and above act as a full word

  always_comb begin
    case (cmd.ksel)
      K_P1:    kval = P1;
      K_P2:    kval = P2;
      K_P3:    kval = P3;
      default: kval = P1;
    endcase
  end

  sxxh_mul u_mul (
    .clk   (clk),
    .en    (cmd.mul_en),
    .phase (cmd.phase),
    .a     (t),
    .b     (kval),
    .sum   (p)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (full || (CNT_W'(i) < cnt_r)) ? word_r[8*i +: 8] : 8'h00;
    end
  end

  assign fin_h = acc ^ {{(WORD_W-LEN_W){1'b0}}, saved_len};
  assign acc_x = acc ^ p;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r  <= in_data[63:0];
      cnt_r   <= in_data[67:64];
      len_in  <= in_data[99:68];
      first_r <= in_user;
      last_r  <= in_last;
    end

    case (cmd.load)
      LD_INIT: begin
        t         <= rotl31(seed + P5 + {{(WORD_W-LEN_W){1'b0}}, len_in});
        saved_len <= len_in;
      end
      LD_WORD: t <= masked;
      LD_FIN:  t <= fin_h ^ (fin_h >> 33);
      default: ;
    endcase

    case (cmd.post)
      POST_ACC:       acc <= p;
      POST_T_ROT31:   t <= rotl31(p);
      POST_XOR_ROT27: begin
        acc <= acc_x;
        t   <= rotl27(acc_x);
      end
      POST_ACC_P4:    acc <= p + P4;
      POST_ACC_XOR:   acc <= acc_x;
      POST_T_XS29:    t <= p ^ (p >> 29);
      POST_OUT:       out_data <= p ^ (p >> 32);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load == LD_INIT) begin
        in_msg <= 1'b1;
      end else if (cmd.post == POST_OUT) begin
        in_msg <= 1'b0;
      end
      if (cmd.post == POST_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.first    = first_r;
    stat.last     = last_r;
    stat.full     = full;
    stat.zero     = (cnt_r == '0);
    stat.in_msg   = in_msg;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

// ----- src/sxxh_ctrl.sv -----
// Controller: sequences loads and multiply passes for each item.
module sxxh_ctrl
  import sxxh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  phase_t ph;
  phase_t ph_next;
  logic   ph_done;

  function automatic state_t mix_target(input stat_t s);
    if (!s.zero) begin
      return ST_WORD_LOAD;
    end else if (s.last) begin
      return ST_FIN_LOAD;
    end
    return ST_IDLE;
  endfunction

  function automatic phase_t step_phase(input phase_t x);
    case (x)
      PH_LL:   return PH_LH;
      PH_LH:   return PH_HL;
      default: return PH_LL;
    endcase
  endfunction

  assign ph_done = (ph == PH_HL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= PH_LL;
    end else begin
      state <= state_next;
      ph    <= ph_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    ph_next    = ph;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.first) begin
          state_next = ST_INIT_LOAD;
        end else if (!stat.in_msg) begin
          state_next = ST_IDLE;
        end else begin
          state_next = mix_target(stat);
        end
      end
      ST_INIT_LOAD: state_next = ST_INIT_MUL;
      ST_WORD_LOAD: state_next = stat.full ? ST_FULL_MUL1 : ST_TAIL_MUL1;
      ST_FIN_LOAD:  state_next = ST_FIN_MUL1;
      ST_INIT_MUL, ST_FULL_MUL1, ST_FULL_MUL2, ST_FULL_MUL3,
      ST_TAIL_MUL1, ST_TAIL_MUL2, ST_FIN_MUL1: begin
        ph_next = step_phase(ph);
        if (ph_done) begin
          case (state)
            ST_INIT_MUL:  state_next = mix_target(stat);
            ST_FULL_MUL1: state_next = ST_FULL_MUL2;
            ST_FULL_MUL2: state_next = ST_FULL_MUL3;
            ST_TAIL_MUL1: state_next = ST_TAIL_MUL2;
            ST_FIN_MUL1:  state_next = ST_FIN_MUL2;
            default:      state_next = stat.last ? ST_FIN_LOAD : ST_IDLE;
          endcase
        end
      end
      ST_FIN_MUL2: begin
        // hold the last pass until the output slot is free
        if (!ph_done) begin
          ph_next = step_phase(ph);
        end else if (stat.out_free) begin
          ph_next    = PH_LL;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        ph_next    = PH_LL;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.load    = LD_NONE;
    cmd.mul_en  = 1'b0;
    cmd.phase   = ph;
    cmd.ksel    = K_P1;
    cmd.post    = POST_NONE;
    case (state)
      ST_INIT_LOAD: cmd.load = LD_INIT;
      ST_WORD_LOAD: cmd.load = LD_WORD;
      ST_FIN_LOAD:  cmd.load = LD_FIN;
      ST_INIT_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P2;
        cmd.post   = ph_done ? POST_ACC : POST_NONE;
      end
      ST_FULL_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P2;
        cmd.post   = ph_done ? POST_T_ROT31 : POST_NONE;
      end
      ST_FULL_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P1;
        cmd.post   = ph_done ? POST_XOR_ROT27 : POST_NONE;
      end
      ST_FULL_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P1;
        cmd.post   = ph_done ? POST_ACC_P4 : POST_NONE;
      end
      ST_TAIL_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P3;
        cmd.post   = ph_done ? POST_T_ROT31 : POST_NONE;
      end
      ST_TAIL_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P1;
        cmd.post   = ph_done ? POST_ACC_XOR : POST_NONE;
      end
      ST_FIN_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.ksel   = K_P2;
        cmd.post   = ph_done ? POST_T_XS29 : POST_NONE;
      end
      ST_FIN_MUL2: begin
        cmd.ksel = K_P3;
        if (!ph_done) begin
          cmd.mul_en = 1'b1;
        end else if (stat.out_free) begin
          cmd.mul_en = 1'b1;
          cmd.post   = POST_OUT;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/simplified_xxhash64_stream_core.sv -----
// Top level of the streaming 64-bit hash core: controller, datapath and ports.
//
// Hashes a message of little-endian 64-bit words with a simplified xxHash64-style
// mix and emits one 64-bit hash per message on the item marked tlast. One item is
// taken at a time; all arithmetic runs through a single 32x32 multiplier that
// builds each 64-bit product in three passes, and that multiplier sets the rate.
// Each item passes the idle and check states; a message start adds the seed load and
// multiply, a nonzero byte count adds a word load and the full- or partial-word
// multiplies, and a message end adds the finish, which waits for a free output slot.
// Items without tuser set that arrive outside a message are dropped. The seed
// register is written through the cfg channel, which is always ready.
module simplified_xxhash64_stream_core
  import sxxh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WORD_W-1:0]     cfg_data,       // hash_seed
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // data_word, byte_count, message_length
  input  logic                  s_axis_tuser,   // first_word
  input  logic                  s_axis_tlast,   // last_word
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [WORD_W-1:0]     m_axis_tdata    // hash_value
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sxxh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sxxh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_en && cmd.post == POST_OUT) |-> stat.out_free)
    else $error("hash written while output slot is occupied");

  a_out_ends_msg: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_en && cmd.post == POST_OUT) |=> (m_axis_tvalid && !stat.in_msg))
    else $error("finished hash did not close the message");

  a_init_opens_msg: assert property (@(posedge clk) disable iff (rst)
    (cmd.load == LD_INIT) |=> stat.in_msg)
    else $error("message start did not mark the block busy");

  a_no_accept_in_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> !s_axis_tready)
    else $error("input ready while the multiplier is in use");
`endif

endmodule

// ----- bench/simplified_xxhash64_stream_checker.sv -----
// Checker for the hash core: tracks the seed and message state, predicts each hash, compares.
module simplified_xxhash64_stream_checker
  import sxxh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [WORD_W-1:0]     cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [WORD_W-1:0]     m_axis_tdata,
  output int unsigned           mismatch_count,
  output int unsigned           pending_hashes
);

  localparam logic [WORD_W-1:0] MIX_P1 = 64'h9E3779B185EBCA87;
  localparam logic [WORD_W-1:0] MIX_P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [WORD_W-1:0] MIX_P3 = 64'h165667B19E3779F9;
  localparam logic [WORD_W-1:0] MIX_P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [WORD_W-1:0] MIX_P5 = 64'h27D4EB2F165667C5;
  localparam logic [CNT_W-1:0]  FULL_COUNT = 4'd8;
  localparam int unsigned       REPORT_LIMIT = 10;

  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] acc;
  logic [LEN_W-1:0]  msg_len;
  logic              msg_active;
  logic [WORD_W-1:0] hash_queue [$];
  int unsigned       errors;

  function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x,
                                                    input int amount);
    return (x << amount) | (x >> (WORD_W - amount));
  endfunction

  function automatic logic [WORD_W-1:0] finish_hash(input logic [WORD_W-1:0] a,
                                                    input logic [LEN_W-1:0] n);
    logic [WORD_W-1:0] h;
    h = a ^ {{(WORD_W-LEN_W){1'b0}}, n};
    h = h ^ (h >> 33);
    h = h * MIX_P2;
    h = h ^ (h >> 29);
    h = h * MIX_P3;
    h = h ^ (h >> 32);
    return h;
  endfunction

  task automatic absorb_item(input logic [IN_TDATA_W-1:0] tdata, input logic first,
                             input logic last);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mask;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  len;
    word = tdata[WORD_W-1:0];
    cnt  = tdata[WORD_W +: CNT_W];
    len  = tdata[WORD_W+CNT_W +: LEN_W];
    if (cnt > FULL_COUNT) cnt = FULL_COUNT;
    if (first) begin
      msg_len    = len;
      acc        = rotate_left(seed_reg + MIX_P5 + {{(WORD_W-LEN_W){1'b0}}, len}, 31) * MIX_P2;
      msg_active = 1'b1;
    end
    // drop stray items that arrive outside a message
    if (msg_active) begin
      if (cnt == FULL_COUNT) begin
        acc = acc ^ (rotate_left(word * MIX_P2, 31) * MIX_P1);
        acc = rotate_left(acc, 27) * MIX_P1 + MIX_P4;
      end else if (cnt != '0) begin
        mask = (64'd1 << (8 * cnt)) - 64'd1;
        acc  = acc ^ (rotate_left((word & mask) * MIX_P3, 31) * MIX_P1);
      end
      if (last) begin
        hash_queue = {hash_queue, finish_hash(acc, msg_len)};
        msg_active = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    logic [WORD_W-1:0] expected;
    if (rst) begin
      seed_reg   = '0;
      acc        = '0;
      msg_len    = '0;
      msg_active = 1'b0;
      errors     = 0;
      hash_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_queue.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected hash %h with no message finished", m_axis_tdata);
        end else begin
          expected = hash_queue.pop_front();
          if (m_axis_tdata !== expected) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("hash mismatch: expected %h, got %h", expected, m_axis_tdata);
          end
        end
      end
      if (cfg_valid && cfg_ready) seed_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    mismatch_count <= errors;
    pending_hashes <= hash_queue.size();
  end

endmodule

// ----- bench/simplified_xxhash64_stream_core_test.sv -----
// Testbench top: drives messages and seed writes into the hash core and gives the verdict.
module simplified_xxhash64_stream_core_test
  import sxxh_pkg::*;
();

  localparam int               HOLD_CYCLES     = 300;
  localparam int               SETTLE_CYCLES   = 40;
  localparam int               QUIET_LIMIT     = 2000;
  localparam int               ITEMS_PER_PHASE = 80;
  localparam int               NUM_PHASES      = 6;
  localparam int               HOLD_PHASE      = 2;
  localparam logic [CNT_W-1:0] FULL_WORD       = 4'd8;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [WORD_W-1:0]     cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;  // data_word, byte_count, message_length
  logic                  s_axis_tuser  = 1'b0;  // first_word
  logic                  s_axis_tlast  = 1'b0;  // last_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;  // hash_value

  int unsigned mismatch_count;
  int unsigned pending_hashes;
  int unsigned items_sent    = 0;
  bit          msg_open      = 1'b0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          quiet_cycles  = 0;
  logic [WORD_W-1:0] seed_list [NUM_PHASES];

  simplified_xxhash64_stream_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  simplified_xxhash64_stream_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .pending_hashes (pending_hashes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] cnt,
                           input logic first, input logic last, input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-WORD_W-CNT_W-LEN_W){1'b0}}, len, cnt, word};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (first || msg_open) begin
      items_sent++;
      msg_open = !last;
    end
  endtask

  // Hold input until every hash is out and the core has finished any trailing item.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_hashes != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message();
    int        pick;
    int        kind;
    int        len_bytes;
    int        n_words;
    int        tail;
    logic [LEN_W-1:0] len_field;
    logic [CNT_W-1:0] cnt;
    logic      first_flag;
    logic      last_flag;
    pick = $urandom_range(0, 19);
    kind = $urandom_range(0, 99);
    if (pick < 14) len_bytes = $urandom_range(0, 24);
    else if (pick < 19) len_bytes = $urandom_range(25, 120);
    else len_bytes = $urandom_range(121, 400);
    n_words   = (len_bytes == 0) ? 1 : (len_bytes + 7) / 8;
    len_field = LEN_W'(len_bytes);
    if (kind >= 88) len_field = $urandom();
    for (int i = 0; i < n_words; i++) begin
      tail       = len_bytes - 8 * i;
      cnt        = (tail >= 8) ? FULL_WORD : CNT_W'(tail);
      first_flag = (i == 0);
      last_flag  = (i == n_words - 1);
      // break some messages: odd counts, restarts, missing or early ends
      if (kind >= 80 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: cnt = CNT_W'($urandom_range(0, 15));
          1: first_flag = 1'b1;
          2: last_flag = 1'b0;
          default: last_flag = 1'b1;
        endcase
      end
      send_item(rand_word(), cnt, first_flag, last_flag, len_field);
    end
  endtask

  initial begin : receiver
    int mode;
    int unsigned cycle;
    mode  = 0;
    cycle = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_requests != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((cycle % 8) < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simplified_xxhash64_stream_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, seed at its reset value
    send_item(rand_word(), 4'd5, 1'b0, 1'b0, 32'd5);          // stray word while idle
    send_item('0, 4'd0, 1'b1, 1'b1, 32'd0);                  // empty message
    send_item('1, 4'd1, 1'b1, 1'b1, 32'd1);
    send_item('1, FULL_WORD, 1'b1, 1'b1, 32'd8);
    send_item('0, FULL_WORD, 1'b1, 1'b1, 32'd8);
    send_item(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_item('1, 4'd7, 1'b0, 1'b1, 32'd0);
    send_item(rand_word(), 4'hF, 1'b1, 1'b1, 32'd8);          // count saturates
    send_item(rand_word(), 4'd9, 1'b1, 1'b0, 32'd27);
    send_item(rand_word(), 4'd0, 1'b0, 1'b0, 32'd0);          // zero count mid-message
    send_item(rand_word(), 4'd3, 1'b0, 1'b0, 32'd0);          // partial, not last
    send_item(rand_word(), FULL_WORD, 1'b0, 1'b0, 32'd0);
    send_item(rand_word(), 4'd0, 1'b0, 1'b1, 32'd0);
    send_item(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd16);
    send_item(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd13);   // restart mid-message
    send_item(rand_word(), 4'd5, 1'b0, 1'b1, 32'd0);
    send_item(rand_word(), 4'd2, 1'b1, 1'b0, 32'd20);        // length does not match
    send_item(rand_word(), FULL_WORD, 1'b0, 1'b1, 32'd20);
    send_item(rand_word(), 4'd6, 1'b1, 1'b1, 32'h8000_0000);

    seed_list[0] = '1;
    seed_list[1] = '0;
    seed_list[2] = rand_word();
    seed_list[3] = 64'd1;
    seed_list[4] = 64'h8000_0000_0000_0000;
    seed_list[5] = rand_word();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_seed(seed_list[p]);
      if (p == HOLD_PHASE) hold_requests++;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(0, 19) == 0)
          send_item(rand_word(), CNT_W'($urandom_range(0, 15)), 1'b0,
                    1'($urandom_range(0, 1)), LEN_W'($urandom()));
        else
          send_message();
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_hashes == 0) begin
      $display("simplified_xxhash64_stream_core_test OK");
    end else begin
      $display("simplified_xxhash64_stream_core_test NOT OK");
    end
    $finish;
  end

endmodule
